// ----- src/shpt_pkg.sv -----
// Types and constants for the stepper homing and position tracker
package shpt_pkg;

    // field widths fixed by the interface
    localparam int RES_W  = 14;
    localparam int HP_W   = 16;
    localparam int FS_W   = 12;
    localparam int BO_W   = 8;
    localparam int IDX_W  = 2;
    localparam int PH_W   = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FULL_SCALE  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BACKOFF     = 2'd2;

    // configuration reset values
    localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd1700;
    localparam logic [FS_W-1:0] FULL_SCALE_RST  = 12'd864;
    localparam logic [BO_W-1:0] BACKOFF_RST     = 8'd30;

    // resistance ceiling: one hundred percent in hundredths
    localparam logic [RES_W-1:0] RES_FULL = 14'd10000;

    // target = floor(prod / 10000) as (prod * RECIP_MULT) >> RECIP_SHIFT,
    // exact for every product below 2^26
    localparam int PROD_W      = RES_W + FS_W;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 40;
    localparam int QPROD_W     = PROD_W + RECIP_W;
    localparam int QUOT_W      = 12;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 27'd109951163;

    // motion phase
    typedef enum logic [PH_W-1:0] {
        PH_HOME    = 2'd0,
        PH_BACKOFF = 2'd1,
        PH_TRACK   = 2'd2
    } t_phase;

endpackage

// ----- src/stepper_homing_position_tracker.sv -----
// Stepper step/dir controller with homing, backoff and resistance tracking
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | i_in_valid, o_in_stall, i_resistance,     | in
//            | i_end_switch_n                            |
//  result    | o_out_valid, i_out_stall, o_step_out,     | out
//            | o_dir_out, o_position, o_phase            |
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,    | in
//            | i_cfg_data                                |
//
// One word in and one word out per clock while the result is not stalled; the
// stages are the input register, resistance-by-scale multiply, reciprocal multiply and state update.
// The step/position state advances once per word in the last stage.
// Reset restores the register defaults and starts homing backward.
// A stalled result holds the whole pipeline and raises o_in_stall.
module stepper_homing_position_tracker #(
    parameter int POSITION_BITS = 12,
    parameter int TIMER_BITS    = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [shpt_pkg::RES_W-1:0]  i_resistance,
    input  logic                        i_end_switch_n,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_step_out,
    output logic                        o_dir_out,
    output logic [POSITION_BITS-1:0]    o_position,
    output logic [shpt_pkg::PH_W-1:0]   o_phase,
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [shpt_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [shpt_pkg::HP_W-1:0]   i_cfg_data
);
    import shpt_pkg::*;

    localparam int CMP_W = (TIMER_BITS > HP_W) ? TIMER_BITS : HP_W;
    localparam int TGT_W = (POSITION_BITS > QUOT_W) ? POSITION_BITS : QUOT_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [CMP_W-1:0] TIMER_MAX_EXT = CMP_W'({TIMER_BITS{1'b1}});

    // configuration registers
    logic [HP_W-1:0] r_cfg_half;
    logic [FS_W-1:0] r_cfg_fs;
    logic [BO_W-1:0] r_cfg_bo;

    // pipeline registers
    logic                  r_s0_valid, r_s1_valid, r_s2_valid;
    logic [RES_W-1:0]      r_s0_res;
    logic                  r_s0_sw, r_s1_sw, r_s2_sw;
    logic [PROD_W-1:0]     r_s1_prod;
    logic [QUOT_W-1:0]     r_s2_quot;

    // controller state
    t_phase                   r_mode, n_mode;
    logic [TIMER_BITS-1:0]    r_tick, n_tick;
    logic                     r_active, n_active;
    logic                     r_high, n_high;
    logic                     r_dir, n_dir;
    logic [BO_W-1:0]          r_bl, n_bl;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    // result register
    logic                     r_out_valid;
    logic                     r_out_step, n_out_step;
    logic                     r_out_dir, n_out_dir;
    logic [POSITION_BITS-1:0] r_out_pos, n_out_pos;
    logic [PH_W-1:0]          r_out_phase, n_out_phase;

    logic                     advance;
    logic                     update;
    logic [RES_W-1:0]         res_sat;
    logic [QPROD_W-1:0]       qprod;
    logic [CMP_W-1:0]         half_ext;
    logic [CMP_W-1:0]         half_eff;
    logic [TIMER_BITS-1:0]    tick_inc;
    logic                     tick_hit;
    logic [BO_W-1:0]          bl_dec;
    logic [POSITION_BITS-1:0] target;
    logic                     step_done;
    logic                     pressed;

    // pipeline moves whenever the result register is free or being taken
    assign advance    = ~r_out_valid | ~i_out_stall;
    assign update     = advance & r_s2_valid;
    assign o_in_stall = ~advance;
    assign o_cfg_ready = 1'b1;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_half <= HALF_PERIOD_RST;
            r_cfg_fs   <= FULL_SCALE_RST;
            r_cfg_bo   <= BACKOFF_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_cfg_half <= i_cfg_data;
                CFG_FULL_SCALE:  r_cfg_fs   <= i_cfg_data[FS_W-1:0];
                CFG_BACKOFF:     r_cfg_bo   <= i_cfg_data[BO_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp resistance to one hundred percent
    assign res_sat = (i_resistance > RES_FULL) ? RES_FULL : i_resistance;

    // divide by 10000 through the reciprocal
    assign qprod = QPROD_W'(r_s1_prod) * QPROD_W'(RECIP_MULT);

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s0_valid <= i_in_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s0_res  <= res_sat;
            r_s0_sw   <= i_end_switch_n;
            r_s1_prod <= PROD_W'(r_s0_res) * PROD_W'(r_cfg_fs);
            r_s1_sw   <= r_s0_sw;
            r_s2_quot <= qprod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
            r_s2_sw   <= r_s1_sw;
        end
    end

    // effective half-period: at least one tick, at most the timer range
    assign half_ext = CMP_W'(r_cfg_half);
    always_comb begin
        if (r_cfg_half == '0) begin
            half_eff = CMP_W'(1);
        end else if (half_ext > TIMER_MAX_EXT) begin
            half_eff = TIMER_MAX_EXT;
        end else begin
            half_eff = half_ext;
        end
    end

    assign tick_inc = r_tick + 1'b1;
    assign tick_hit = CMP_W'(tick_inc) >= half_eff;
    assign bl_dec   = (r_bl != '0) ? r_bl - 1'b1 : r_bl;
    assign pressed  = ~r_s2_sw;

    // target clamped to the position range
    assign target = (TGT_W'(r_s2_quot) > TGT_W'(POS_MAX)) ? POS_MAX
                                                          : POSITION_BITS'(r_s2_quot);

    // next state: pulse timing, step completion, new step start
    always_comb begin
        n_mode    = r_mode;
        n_tick    = r_tick;
        n_active  = r_active;
        n_high    = r_high;
        n_dir     = r_dir;
        n_bl      = r_bl;
        n_pos     = r_pos;
        step_done = 1'b0;

        if (r_active) begin
            n_tick = tick_inc;
            if (tick_hit) begin
                n_tick = '0;
                if (r_high) begin
                    n_high = 1'b0;
                end else begin
                    n_active  = 1'b0;
                    step_done = 1'b1;
                end
            end
        end

        if (step_done) begin
            case (r_mode)
                PH_HOME: begin
                    if (pressed) begin
                        n_bl = r_cfg_bo;
                        if (r_cfg_bo == '0) begin
                            n_mode = PH_TRACK;
                            n_pos  = '0;
                        end else begin
                            n_mode = PH_BACKOFF;
                        end
                    end
                end
                PH_BACKOFF: begin
                    n_bl = bl_dec;
                    if (bl_dec == '0) begin
                        n_mode = PH_TRACK;
                        n_pos  = POSITION_BITS'(r_cfg_bo);
                    end
                end
                default: begin
                    n_pos = r_dir ? r_pos + 1'b1 : r_pos - 1'b1;
                end
            endcase
        end

        if (!n_active) begin
            case (n_mode)
                PH_HOME: begin
                    n_active = 1'b1;
                    n_high   = 1'b1;
                    n_tick   = '0;
                    n_dir    = 1'b0;
                end
                PH_BACKOFF: begin
                    n_active = 1'b1;
                    n_high   = 1'b1;
                    n_tick   = '0;
                    n_dir    = 1'b1;
                end
                default: begin
                    if (target != n_pos) begin
                        n_active = 1'b1;
                        n_high   = 1'b1;
                        n_tick   = '0;
                        n_dir    = target > n_pos;
                    end
                end
            endcase
        end
    end

    // result word from the updated state
    always_comb begin
        n_out_step  = n_active & n_high;
        n_out_dir   = n_dir;
        n_out_pos   = n_pos;
        n_out_phase = n_mode;
    end

    // controller state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= PH_HOME;
            r_tick   <= '0;
            r_active <= 1'b0;
            r_high   <= 1'b0;
            r_dir    <= 1'b0;
            r_bl     <= '0;
            r_pos    <= '0;
        end else if (update) begin
            r_mode   <= n_mode;
            r_tick   <= n_tick;
            r_active <= n_active;
            r_high   <= n_high;
            r_dir    <= n_dir;
            r_bl     <= n_bl;
            r_pos    <= n_pos;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (update) begin
            r_out_step  <= n_out_step;
            r_out_dir   <= n_out_dir;
            r_out_pos   <= n_out_pos;
            r_out_phase <= n_out_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_step_out  = r_out_step;
    assign o_dir_out   = r_out_dir;
    assign o_position  = r_out_pos;
    assign o_phase     = r_out_phase;

endmodule
